[hdl/chkv_pkg.sv]
`timescale 1ns / 1ps
package chkv_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VAL_BITS   = 32;
   localparam int COUNT_BITS = 7;
   localparam int USED_BITS  = 32;
   localparam int UB_BITS    = 5;
   localparam int BUCKETS    = 127;
   localparam int BW         = 7;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_HASH,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_HEAD,
      BK_WALK,
      BK_ACT,
      BK_SCAN,
      BK_FREE
   } back_state_type;

endpackage

[hdl/chkv_front.sv]
`timescale 1ns / 1ps
module chkv_front
   import chkv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                cleared,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [KEY_BITS-1:0] req_key_id,
   input  logic [VAL_BITS-1:0] req_new_value,
   output logic                q_valid,
   input  logic                q_ready,
   output logic                q_op,
   output logic [KEY_BITS-1:0] q_key,
   output logic [VAL_BITS-1:0] q_val,
   output logic [BW-1:0]       q_bucket
);

   front_state_type           state_ff, state_in;
   logic                      op_ff, op_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [VAL_BITS-1:0]       val_ff, val_in;
   logic [BW-1:0]             rem_ff, rem_in;
   logic [9:0]                fold_lo;
   logic [7:0]                fold_hi;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (req_valid && cleared) begin
               state_in = FR_HASH;
            end
         end
         FR_HASH: begin
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (q_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      q_valid   = 1'b0;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      rem_in    = rem_ff;
      // fold the key in 7-bit digits: 128 wraps to 1 modulo 127
      fold_lo   = 10'(key_ff[6:0]) + 10'(key_ff[13:7]) + 10'(key_ff[20:14])
                + 10'(key_ff[27:21]) + 10'(key_ff[31:28]);
      fold_hi   = 8'(fold_lo[6:0]) + 8'(fold_lo[9:7]);
      case (state_ff)
         FR_IDLE: begin
            req_ready = cleared;
            op_in     = req_op;
            key_in    = req_key_id;
            val_in    = req_new_value;
         end
         FR_HASH: begin
            rem_in = (fold_hi >= 8'(BUCKETS)) ? BW'(fold_hi - 8'(BUCKETS)) : BW'(fold_hi);
         end
         FR_PUSH: begin
            q_valid = 1'b1;
         end
         default: begin
            q_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign q_op     = op_ff;
   assign q_key    = key_ff;
   assign q_val    = val_ff;
   assign q_bucket = rem_ff;

endmodule

[hdl/chkv_fifo.sv]
`timescale 1ns / 1ps
module chkv_fifo
   import chkv_pkg::*;
#(
   parameter int WIDTH = 72
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   always_comb begin
      in_ready  = (fill_ff != 2'd2);
      out_valid = (fill_ff != 2'd0);
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wptr_in   = push ? !wptr_ff : wptr_ff;
      rptr_in   = pop ? !rptr_ff : rptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
      out_data  = mem_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= in_data;
      end
   end

endmodule

[hdl/chkv_back.sv]
`timescale 1ns / 1ps
module chkv_back
   import chkv_pkg::*;
#(
   parameter int ENTRIES = 64,
   parameter int EW      = 6,
   parameter int CW      = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VAL_BITS-1:0]   nil_value,
   output logic                  cleared,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic                  q_op,
   input  logic [KEY_BITS-1:0]   q_key,
   input  logic [VAL_BITS-1:0]   q_val,
   input  logic [BW-1:0]         q_bucket,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VAL_BITS-1:0]   rsp_read_value,
   output logic                  rsp_was_present,
   output logic [COUNT_BITS-1:0] rsp_live_count,
   output logic                  rsp_status
);

   localparam int UDEPTH = (ENTRIES + USED_BITS - 1) / USED_BITS;
   localparam int UAW    = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
   localparam int SWEEP  = (BUCKETS > UDEPTH) ? BUCKETS : UDEPTH;
   localparam int CLW    = (SWEEP > 1) ? $clog2(SWEEP) : 1;
   localparam int SW     = EW + 1 + KEY_BITS + VAL_BITS;
   localparam logic [CLW-1:0] SWEEP_LAST = CLW'(SWEEP - 1);
   localparam logic [UAW-1:0] UWORD_LAST = UAW'(UDEPTH - 1);

   logic [EW:0]            head_mem [BUCKETS];
   logic [SW-1:0]          slot_mem [ENTRIES];
   logic [USED_BITS-1:0]   used_mem [UDEPTH];

   logic                   head_we, head_re;
   logic [BW-1:0]          head_waddr, head_raddr;
   logic [EW:0]            head_wdata, head_q;
   logic                   slot_we, slot_re;
   logic [EW-1:0]          slot_waddr, slot_raddr;
   logic [SW-1:0]          slot_wdata, slot_q;
   logic                   used_we, used_re;
   logic [UAW-1:0]         used_waddr, used_raddr;
   logic [USED_BITS-1:0]   used_wdata, used_q;

   back_state_type         state_ff, state_in;
   logic [CLW-1:0]         clr_ff, clr_in;
   logic                   op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VAL_BITS-1:0]    val_ff, val_in;
   logic [BW-1:0]          bkt_ff, bkt_in;
   logic [EW-1:0]          cur_ff, cur_in;
   logic [EW-1:0]          prev_ff, prev_in;
   logic                   has_prev_ff, has_prev_in;
   logic [SW-1:0]          prev_ent_ff, prev_ent_in;
   logic                   found_ff, found_in;
   logic [UAW-1:0]         word_ff, word_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   match, slot_nv, is_set, is_nil;
   logic [EW-1:0]          slot_next;
   logic [USED_BITS-1:0]   avail;
   logic                   any_free;
   logic [UB_BITS-1:0]     pick;
   logic [EW-1:0]          new_slot;
   logic [UAW-1:0]         cur_word;
   logic [UB_BITS-1:0]     cur_bit;
   logic                   finish;
   logic                   fin_status;

   always_comb begin
      match     = (slot_q[VAL_BITS +: KEY_BITS] == key_ff);
      slot_nv   = slot_q[SW-1];
      slot_next = slot_q[KEY_BITS+VAL_BITS +: EW];
      is_set    = (op_ff == OP_SET);
      is_nil    = (val_ff == nil_value);
      cur_word  = UAW'(cur_ff >> UB_BITS);
      cur_bit   = UB_BITS'(cur_ff);
      for (int j = 0; j < USED_BITS; j++) begin
         avail[j] = !used_q[j] && ((int'(word_ff) * USED_BITS + j) < ENTRIES);
      end
      any_free = |avail;
      pick     = '0;
      for (int j = USED_BITS - 1; j >= 0; j--) begin
         if (avail[j]) begin
            pick = UB_BITS'(j);
         end
      end
      new_slot = EW'((int'(word_ff) << UB_BITS) + int'(pick));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == SWEEP_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               state_in = BK_HEAD;
            end
         end
         BK_HEAD: begin
            state_in = head_q[EW] ? BK_WALK : BK_ACT;
         end
         BK_WALK: begin
            if (match || !slot_nv) begin
               state_in = BK_ACT;
            end
         end
         BK_ACT: begin
            if (!is_set || (is_nil && !found_ff)) begin
               state_in = BK_IDLE;
            end else if (is_nil) begin
               state_in = BK_FREE;
            end else if (found_ff) begin
               state_in = BK_IDLE;
            end else begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (any_free || word_ff == UWORD_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_FREE: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cleared     = (state_ff != BK_CLEAR);
      q_ready     = 1'b0;
      head_we     = 1'b0;
      head_waddr  = bkt_ff;
      head_wdata  = '0;
      head_re     = 1'b0;
      head_raddr  = q_bucket;
      slot_we     = 1'b0;
      slot_waddr  = cur_ff;
      slot_wdata  = '0;
      slot_re     = 1'b0;
      slot_raddr  = slot_next;
      used_we     = 1'b0;
      used_waddr  = word_ff;
      used_wdata  = '0;
      used_re     = 1'b0;
      used_raddr  = '0;
      clr_in      = clr_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      bkt_in      = bkt_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      prev_ent_in = prev_ent_ff;
      found_in    = found_ff;
      word_in     = word_ff;
      count_in    = count_ff;
      finish      = 1'b0;
      fin_status  = STATUS_DONE;
      rsp_value_in   = rsp_value_ff;
      rsp_present_in = rsp_present_ff;
      case (state_ff)
         BK_CLEAR: begin
            clr_in     = clr_ff + 1'b1;
            head_we    = (int'(clr_ff) < BUCKETS);
            head_waddr = BW'(clr_ff);
            used_we    = (int'(clr_ff) < UDEPTH);
            used_waddr = UAW'(clr_ff);
         end
         BK_IDLE: begin
            q_ready     = !rsp_valid_ff;
            head_re     = 1'b1;
            op_in       = q_op;
            key_in      = q_key;
            val_in      = q_val;
            bkt_in      = q_bucket;
            has_prev_in = 1'b0;
            found_in    = 1'b0;
         end
         BK_HEAD: begin
            slot_re    = head_q[EW];
            slot_raddr = head_q[EW-1:0];
            cur_in     = head_q[EW-1:0];
         end
         BK_WALK: begin
            if (match) begin
               found_in = 1'b1;
            end else if (slot_nv) begin
               slot_re     = 1'b1;
               cur_in      = slot_next;
               prev_in     = cur_ff;
               prev_ent_in = slot_q;
               has_prev_in = 1'b1;
            end
         end
         BK_ACT: begin
            rsp_value_in   = found_ff ? slot_q[VAL_BITS-1:0] : nil_value;
            rsp_present_in = found_ff;
            if (!is_set || (is_nil && !found_ff)) begin
               finish = 1'b1;
            end else if (is_nil) begin
               if (has_prev_ff) begin
                  slot_we    = 1'b1;
                  slot_waddr = prev_ff;
                  slot_wdata = {slot_q[SW-1 -: EW+1],
                                prev_ent_ff[KEY_BITS+VAL_BITS-1:0]};
               end else begin
                  head_we    = 1'b1;
                  head_wdata = {slot_nv, slot_next};
               end
               used_re    = 1'b1;
               used_raddr = cur_word;
               count_in   = count_ff - 1'b1;
            end else if (found_ff) begin
               slot_we    = 1'b1;
               slot_wdata = {slot_q[SW-1 -: EW+1+KEY_BITS], val_ff};
               finish     = 1'b1;
            end else begin
               used_re    = 1'b1;
               used_raddr = '0;
               word_in    = '0;
            end
         end
         BK_SCAN: begin
            if (any_free) begin
               used_we    = 1'b1;
               used_wdata = used_q | (USED_BITS'(1) << pick);
               slot_we    = 1'b1;
               slot_waddr = new_slot;
               slot_wdata = {head_q, key_ff, val_ff};
               head_we    = 1'b1;
               head_wdata = {1'b1, new_slot};
               count_in   = count_ff + 1'b1;
               finish     = 1'b1;
            end else if (word_ff == UWORD_LAST) begin
               finish     = 1'b1;
               fin_status = STATUS_FULL;
            end else begin
               used_re    = 1'b1;
               used_raddr = word_ff + 1'b1;
               word_in    = word_ff + 1'b1;
            end
         end
         BK_FREE: begin
            used_we    = 1'b1;
            used_waddr = cur_word;
            used_wdata = used_q & ~(USED_BITS'(1) << cur_bit);
            finish     = 1'b1;
         end
         default: begin
            finish = 1'b0;
         end
      endcase
      rsp_valid_in  = finish || (rsp_valid_ff && !rsp_ready);
      rsp_count_in  = finish ? COUNT_BITS'(count_in) : rsp_count_ff;
      rsp_status_in = finish ? fin_status : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_q <= head_mem[head_raddr];
      end
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_q <= slot_mem[slot_raddr];
      end
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      if (used_re) begin
         used_q <= used_mem[used_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      bkt_ff         <= bkt_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      has_prev_ff    <= has_prev_in;
      prev_ent_ff    <= prev_ent_in;
      found_ff       <= found_in;
      word_ff        <= word_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_live_count  = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[hdl/chained_hash_key_value_store.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_op, req_key_id, req_new_value
// rsp_      out        rsp_valid/rsp_ready  rsp_read_value, rsp_was_present,
//                                           rsp_live_count, rsp_status
// csr_      in         csr_wr_en            csr_wr_data (nil value)
//
// The front accepts an item, folds the key modulo BUCKETS and pushes it, taking no new item
// until the push is taken. The back reads the chain head, walks the chain, frees a slot on a
// remove and scans up to ENTRIES/32 free-slot words on an insert; it sets the sustained rate.
// A result waiting on rsp_ready holds the back in idle until it is taken.
// After reset, a pass clears the chain heads and used-slot words; req_ready stays low.
// A two-item queue lets the front hash while the back walks a chain or waits on rsp_ready.
module chained_hash_key_value_store
   import chkv_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [VAL_BITS-1:0]   csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [KEY_BITS-1:0]   req_key_id,
   input  logic [VAL_BITS-1:0]   req_new_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VAL_BITS-1:0]   rsp_read_value,
   output logic                  rsp_was_present,
   output logic [COUNT_BITS-1:0] rsp_live_count,
   output logic                  rsp_status
);

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int QW = 1 + KEY_BITS + VAL_BITS + BW;

   logic [VAL_BITS-1:0] nil_ff, nil_in;
   logic                cleared;
   logic                fq_valid, fq_ready, bq_valid, bq_ready;
   logic                f_op;
   logic [KEY_BITS-1:0] f_key;
   logic [VAL_BITS-1:0] f_val;
   logic [BW-1:0]       f_bucket;
   logic [QW-1:0]       bq_data;

   assign nil_in = csr_wr_en ? csr_wr_data : nil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nil_ff <= '0;
      end else begin
         nil_ff <= nil_in;
      end
   end

   chkv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cleared       (cleared),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_key_id    (req_key_id),
      .req_new_value (req_new_value),
      .q_valid       (fq_valid),
      .q_ready       (fq_ready),
      .q_op          (f_op),
      .q_key         (f_key),
      .q_val         (f_val),
      .q_bucket      (f_bucket)
   );

   chkv_fifo #(.WIDTH(QW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({f_op, f_key, f_val, f_bucket}),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   chkv_back #(
      .ENTRIES (ENTRIES),
      .EW      (EW),
      .CW      (CW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .nil_value       (nil_ff),
      .cleared         (cleared),
      .q_valid         (bq_valid),
      .q_ready         (bq_ready),
      .q_op            (bq_data[QW-1]),
      .q_key           (bq_data[VAL_BITS+BW +: KEY_BITS]),
      .q_val           (bq_data[BW +: VAL_BITS]),
      .q_bucket        (bq_data[BW-1:0]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_was_present (rsp_was_present),
      .rsp_live_count  (rsp_live_count),
      .rsp_status      (rsp_status)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_present |-> rsp_read_value == nil_ff)
      else $error("absent item does not report the nil value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> !rsp_was_present)
      else $error("dropped insert reports a stored key");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front accepted an item while hashing");

   assert property (@(posedge clock) disable iff (reset)
      !cleared |-> !req_ready && !rsp_valid)
      else $error("item traffic during the clearing pass");
`endif

endmodule
